>>> sv/cgbm_pkg.sv
// shared constants, types and helper functions of the correlated gbm path stepper
`timescale 1ns / 1ps
`default_nettype none
package cgbm_pkg;

	localparam int unsigned MaxSteps = 1024;
	localparam int unsigned StepW = $clog2(MaxSteps);
	localparam int unsigned LenW = StepW + 1;

	localparam logic [30:0] Log2eQ30 = 31'd1549082005;
	localparam logic [29:0] Ln2Q30 = 30'd744261118;
	localparam logic [31:0] OneQ30 = 32'h4000_0000;
	localparam logic [31:0] PriceMax = 32'hFFFF_FFFF;

	localparam logic [2:0] RegDriftOne = 3'd0;
	localparam logic [2:0] RegVolOne = 3'd1;
	localparam logic [2:0] RegSpotOne = 3'd2;
	localparam logic [2:0] RegDriftTwo = 3'd3;
	localparam logic [2:0] RegVolTwo = 3'd4;
	localparam logic [2:0] RegSpotTwo = 3'd5;
	localparam logic [2:0] RegRho = 3'd6;
	localparam logic [2:0] RegSteps = 3'd7;

	typedef struct packed {
		logic start;
		logic negate;
	} lane_cmd_t;

	// floor((2^32 - 1) / k), low by at most one after the high-word take
	function automatic logic [31:0] recip(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd1: r = 32'(64'd4294967295 / 64'd1);
			4'd2: r = 32'(64'd4294967295 / 64'd2);
			4'd3: r = 32'(64'd4294967295 / 64'd3);
			4'd4: r = 32'(64'd4294967295 / 64'd4);
			4'd5: r = 32'(64'd4294967295 / 64'd5);
			4'd6: r = 32'(64'd4294967295 / 64'd6);
			4'd7: r = 32'(64'd4294967295 / 64'd7);
			4'd8: r = 32'(64'd4294967295 / 64'd8);
			4'd9: r = 32'(64'd4294967295 / 64'd9);
			4'd10: r = 32'(64'd4294967295 / 64'd10);
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/cgbm_if.sv
// word channel interfaces for samples in and prices out
`timescale 1ns / 1ps
`default_nettype none
interface cgbm_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] normal_one;
	logic signed [15:0] normal_two;
	logic antithetic;
	modport source(output valid, normal_one, normal_two, antithetic, input ready);
	modport sink(input valid, normal_one, normal_two, antithetic, output ready);
endinterface

interface cgbm_price_if;
	logic valid;
	logic ready;
	logic [31:0] price_one;
	logic [31:0] price_two;
	logic [cgbm_pkg::LenW-1:0] step_index;
	logic path_end;
	modport source(output valid, price_one, price_two, step_index, path_end, input ready);
	modport sink(input valid, price_one, price_two, step_index, path_end, output ready);
endinterface
`default_nettype wire

>>> sv/cgbm_corr.sv
// sqrt(1 - rho^2) by digit recurrence and correlation of the second sample
`timescale 1ns / 1ps
`default_nettype none
module cgbm_corr (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] rho,
	input  wire logic signed [15:0] z1,
	input  wire logic signed [15:0] z2,
	output logic                    done,
	output logic signed [16:0]      z2c
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQ = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_SUM = 2'd3;

	logic [1:0] state_q;
	logic [3:0] i_q;
	logic [31:0] d_q;
	logic [31:0] res_q;
	logic signed [31:0] pa_q;
	logic signed [32:0] pb_q;
	logic done_q;
	logic signed [16:0] z2c_q;

	logic signed [31:0] rr;
	logic [31:0] bitv;
	logic [31:0] trial;
	logic signed [16:0] s_w;
	logic signed [33:0] sum_w;

	function automatic logic [31:0] OneQ30Sub(input logic signed [31:0] sq);
		return cgbm_pkg::OneQ30 - sq;
	endfunction

	always_comb begin
		rr = rho * rho;
		bitv = 32'd1 << {i_q, 1'b0};
		trial = res_q + bitv;
		s_w = $signed({1'b0, res_q[15:0]});
		sum_w = 34'(pa_q) + 34'(pb_q) + 34'sd16384;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			i_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						d_q <= OneQ30Sub(rr);
						res_q <= 32'd0;
						i_q <= 4'd15;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (d_q >= trial) begin
						d_q <= d_q - trial;
						res_q <= (res_q >> 1) + bitv;
					end else begin
						res_q <= res_q >> 1;
					end
					if (i_q == 4'd0) state_q <= ST_MUL;
					else i_q <= i_q - 4'd1;
				end
				ST_MUL: begin
					pa_q <= rho * z1;
					pb_q <= s_w * z2;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					z2c_q <= sum_w[31:15];
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign z2c = z2c_q;
endmodule
`default_nettype wire

>>> sv/cgbm_lane.sv
// one asset lane: log return, fixed point exponential and price update
`timescale 1ns / 1ps
`default_nettype none
module cgbm_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cgbm_pkg::lane_cmd_t cmd,
	input  wire logic signed [31:0]  drift,
	input  wire logic [30:0]         vol,
	input  wire logic signed [16:0]  z,
	input  wire logic [31:0]         price_in,
	output logic                     done,
	output logic [31:0]              price_out
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LR = 4'd1;
	localparam logic [3:0] ST_Y = 4'd2;
	localparam logic [3:0] ST_X = 4'd3;
	localparam logic [3:0] ST_H1 = 4'd4;
	localparam logic [3:0] ST_H2 = 4'd5;
	localparam logic [3:0] ST_H3 = 4'd6;
	localparam logic [3:0] ST_PM = 4'd7;
	localparam logic [3:0] ST_SH = 4'd8;
	localparam logic signed [31:0] Log2eS = $signed({1'b0, cgbm_pkg::Log2eQ30});

	logic [3:0] state_q;
	logic neg_q;
	logic signed [48:0] prod_q;
	logic signed [54:0] mh_q;
	logic [45:0] ml_q;
	logic signed [9:0] n_q;
	logic [29:0] f_q;
	logic [29:0] x_q;
	logic [31:0] t_q;
	logic [3:0] k_q;
	logic [61:0] pr_q;
	logic [31:0] q_q;
	logic [63:0] qr_q;
	logic [63:0] p_q;
	logic [31:0] price_q;
	logic done_q;

	logic signed [48:0] rnd_w;
	logic signed [37:0] r_w;
	logic signed [37:0] lr_w;
	logic signed [22:0] hi_w;
	logic [14:0] lo_w;
	logic signed [54:0] ysum_w;
	logic signed [39:0] y_w;
	logic [59:0] xf_w;
	logic [31:0] q_w;
	logic [31:0] qh_w;
	logic [35:0] qk_w;
	logic [31:0] rem_w;
	logic signed [10:0] s_w;
	logic [10:0] ls_w;
	logic [63:0] rs_w;
	logic [31:0] res_w;

	always_comb begin
		rnd_w = prod_q + 49'sd2048;
		r_w = 38'(rnd_w >>> 12);
		lr_w = neg_q ? (38'(drift) - r_w) : (38'(drift) + r_w);
		hi_w = lr_w[37:15];
		lo_w = lr_w[14:0];
		ysum_w = mh_q + $signed({9'd0, ml_q[45:15]});
		y_w = 40'(ysum_w >>> 15);
		xf_w = f_q * cgbm_pkg::Ln2Q30;
		q_w = pr_q[61:30];
		qh_w = qr_q[63:32];
		qk_w = qh_w * k_q;
		rem_w = q_q - qk_w[31:0];
		s_w = 11'sd30 - 11'(n_q);
		ls_w = 11'(-s_w);
		rs_w = p_q >> s_w[5:0];
		res_w = 32'd0;
		if (s_w >= 11'sd64) begin
			res_w = 32'd0;
		end else if (s_w >= 11'sd0) begin
			res_w = (|rs_w[63:32]) ? cgbm_pkg::PriceMax : rs_w[31:0];
		end else if (p_q == 64'd0) begin
			res_w = 32'd0;
		end else if (ls_w >= 11'd32) begin
			res_w = cgbm_pkg::PriceMax;
		end else if (p_q > ({32'd0, cgbm_pkg::PriceMax} >> ls_w[4:0])) begin
			res_w = cgbm_pkg::PriceMax;
		end else begin
			res_w = 32'(p_q << ls_w[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			k_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						neg_q <= cmd.negate;
						prod_q <= $signed({1'b0, vol}) * z;
						state_q <= ST_LR;
					end
				end
				ST_LR: begin
					mh_q <= hi_w * Log2eS;
					ml_q <= lo_w * cgbm_pkg::Log2eQ30;
					state_q <= ST_Y;
				end
				ST_Y: begin
					n_q <= y_w[39:30];
					f_q <= y_w[29:0];
					state_q <= ST_X;
				end
				ST_X: begin
					x_q <= xf_w[59:30];
					t_q <= cgbm_pkg::OneQ30;
					k_q <= 4'd10;
					state_q <= ST_H1;
				end
				ST_H1: begin
					pr_q <= x_q * t_q;
					state_q <= ST_H2;
				end
				ST_H2: begin
					q_q <= q_w;
					qr_q <= q_w * cgbm_pkg::recip(k_q);
					state_q <= ST_H3;
				end
				ST_H3: begin
					t_q <= cgbm_pkg::OneQ30 + qh_w + 32'(rem_w >= {28'd0, k_q});
					if (k_q == 4'd1) begin
						state_q <= ST_PM;
					end else begin
						k_q <= k_q - 4'd1;
						state_q <= ST_H1;
					end
				end
				ST_PM: begin
					p_q <= price_in * t_q;
					state_q <= ST_SH;
				end
				ST_SH: begin
					price_q <= res_w;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign price_out = price_q;
endmodule
`default_nettype wire

>>> sv/correlated_gbm_path_stepper_unit.sv
// top level: apb registers, path state, two asset lanes and the merged output word
// a sample word is taken only while idle, and the next one only once the previous word has
// moved to the output register; the pace is set by the 16-step square root followed by
// the ten-term exponential that both lanes run side by side
// a finished word waits in the output register while the next sample is taken
// reset: async active low; registers to their reset values, path restarts at step one
`timescale 1ns / 1ps
`default_nettype none
module correlated_gbm_path_stepper_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	cgbm_sample_if.sink      sample,
	cgbm_price_if.source     price
);
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_CORR = 2'd1;
	localparam logic [1:0] T_LANE = 2'd2;
	localparam logic [1:0] T_OUT = 2'd3;
	localparam int unsigned SW = cgbm_pkg::StepW;
	localparam int unsigned LW = cgbm_pkg::LenW;

	logic [31:0] drift_one_q, spot_one_q, drift_two_q, spot_two_q;
	logic [30:0] vol_one_q, vol_two_q;
	logic [15:0] rho_q;
	logic [LW-1:0] steps_q;

	logic [1:0] state_q;
	logic [31:0] running_one_q, running_two_q;
	logic [SW-1:0] step_count_q;
	logic [SW-1:0] j_q;
	logic [LW-1:0] len_q;
	logic signed [15:0] z1_q, z2_q;
	logic anti_q;
	logic corr_go_q;

	logic ov_q;
	logic [31:0] out_one_q, out_two_q;
	logic [LW-1:0] out_idx_q;
	logic out_end_q;

	logic wr;
	logic accept;
	logic [LW-1:0] len_w;
	logic [SW-1:0] j_w;
	logic [LW-1:0] next_w;
	logic last_w;
	logic corr_done;
	logic signed [16:0] z2c;
	cgbm_pkg::lane_cmd_t cmd;
	logic done_one, done_two;
	logic [31:0] new_one, new_two;
	logic load_out;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_one_q <= 32'd0;
			vol_one_q <= 31'd0;
			spot_one_q <= 32'h0001_0000;
			drift_two_q <= 32'd0;
			vol_two_q <= 31'd0;
			spot_two_q <= 32'h0001_0000;
			rho_q <= 16'd0;
			steps_q <= LW'(1);
		end else if (wr) begin
			unique case (paddr[4:2])
				cgbm_pkg::RegDriftOne: drift_one_q <= pwdata;
				cgbm_pkg::RegVolOne: vol_one_q <= pwdata[30:0];
				cgbm_pkg::RegSpotOne: spot_one_q <= pwdata;
				cgbm_pkg::RegDriftTwo: drift_two_q <= pwdata;
				cgbm_pkg::RegVolTwo: vol_two_q <= pwdata[30:0];
				cgbm_pkg::RegSpotTwo: spot_two_q <= pwdata;
				cgbm_pkg::RegRho: rho_q <= pwdata[15:0];
				cgbm_pkg::RegSteps: steps_q <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			cgbm_pkg::RegDriftOne: prdata = drift_one_q;
			cgbm_pkg::RegVolOne: prdata = {1'b0, vol_one_q};
			cgbm_pkg::RegSpotOne: prdata = spot_one_q;
			cgbm_pkg::RegDriftTwo: prdata = drift_two_q;
			cgbm_pkg::RegVolTwo: prdata = {1'b0, vol_two_q};
			cgbm_pkg::RegSpotTwo: prdata = spot_two_q;
			cgbm_pkg::RegRho: prdata = {16'd0, rho_q};
			cgbm_pkg::RegSteps: prdata = {{(32 - LW){1'b0}}, steps_q};
			default: prdata = 32'd0;
		endcase
	end

	assign sample.ready = (state_q == T_IDLE);
	assign accept = sample.valid & sample.ready;

	always_comb begin
		if (steps_q == '0) len_w = LW'(1);
		else if (steps_q > LW'(cgbm_pkg::MaxSteps)) len_w = LW'(cgbm_pkg::MaxSteps);
		else len_w = steps_q;
		j_w = ({1'b0, step_count_q} >= len_w) ? '0 : step_count_q;
		next_w = {1'b0, j_q} + LW'(1);
		last_w = (next_w == len_q);
	end

	cgbm_corr u_corr (
		.clk(clk),
		.arst_n(arst_n),
		.start(corr_go_q),
		.rho(rho_q),
		.z1(z1_q),
		.z2(z2_q),
		.done(corr_done),
		.z2c(z2c)
	);

	assign cmd.start = (state_q == T_CORR) & corr_done;
	assign cmd.negate = anti_q & j_q[0];

	cgbm_lane u_lane_one (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.drift(drift_one_q),
		.vol(vol_one_q),
		.z(17'(z1_q)),
		.price_in(running_one_q),
		.done(done_one),
		.price_out(new_one)
	);

	cgbm_lane u_lane_two (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.drift(drift_two_q),
		.vol(vol_two_q),
		.z(z2c),
		.price_in(running_two_q),
		.done(done_two),
		.price_out(new_two)
	);

	assign load_out = (state_q == T_OUT) & (~ov_q | price.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			running_one_q <= 32'd0;
			running_two_q <= 32'd0;
			step_count_q <= '0;
			corr_go_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			corr_go_q <= accept;
			if (load_out) ov_q <= 1'b1;
			else if (price.ready) ov_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						z1_q <= sample.normal_one;
						z2_q <= sample.normal_two;
						anti_q <= sample.antithetic;
						j_q <= j_w;
						len_q <= len_w;
						if (j_w == '0) begin
							running_one_q <= spot_one_q;
							running_two_q <= spot_two_q;
						end
						state_q <= T_CORR;
					end
				end
				T_CORR: if (corr_done) state_q <= T_LANE;
				T_LANE: if (done_one & done_two) state_q <= T_OUT;
				T_OUT: begin
					if (load_out) begin
						out_one_q <= new_one;
						out_two_q <= new_two;
						out_idx_q <= next_w;
						out_end_q <= last_w;
						running_one_q <= new_one;
						running_two_q <= new_two;
						step_count_q <= last_w ? '0 : next_w[SW-1:0];
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign price.valid = ov_q;
	assign price.price_one = out_one_q;
	assign price.price_two = out_two_q;
	assign price.step_index = out_idx_q;
	assign price.path_end = out_end_q;
endmodule
`default_nettype wire

>>> sv/cgbm_checker.sv
// port-level checker for the path stepper and its bind
`timescale 1ns / 1ps
`default_nettype none
module cgbm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_valid,
	input wire logic        s_ready,
	input wire logic        p_valid,
	input wire logic        p_ready,
	input wire logic [10:0] p_index,
	input wire logic        p_end
);
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample taken while a word is still in work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && !p_ready |=> p_valid && $stable(p_index) && $stable(p_end))
		else $error("price word dropped or changed while stalled");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid |-> p_index != 11'd0 && p_index <= 11'd1024)
		else $error("step index out of range");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !(p_valid && !$past(p_valid)))
		else $error("price word appeared one cycle after a sample");

	a_reset: assert property (@(posedge clk) !arst_n |=> !p_valid && s_ready)
		else $error("outputs not idle after reset");
endmodule

bind correlated_gbm_path_stepper_unit cgbm_checker u_cgbm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_valid(sample.valid),
	.s_ready(sample.ready),
	.p_valid(price.valid),
	.p_ready(price.ready),
	.p_index(price.step_index),
	.p_end(price.path_end)
);
`default_nettype wire
